>>> rtl/core/slc_pkg.sv
package slc_pkg;

  localparam int LIN_W   = 20 + 1;
  localparam int LIN_SH  = 20;
  localparam int N_W     = 44;
  localparam int Q_W     = 21;
  localparam int REM_W   = 26;
  localparam int LNUM_W  = 29;
  localparam int CB_STEPS = 21;
  localparam int FRAC_BITS_DEF = 8;

  typedef logic [LIN_W-1:0]  lin_t;
  typedef logic [N_W-1:0]    num_t;
  typedef logic [Q_W-1:0]    ratio_t;
  typedef logic [REM_W-1:0]  rem_t;
  typedef logic [LNUM_W-1:0] lnum_t;

  // rgb to xyz matrix, scaled by 1e7
  localparam logic [23:0] MAT [3][3] = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339,  24'd1191920, 24'd9503041}
  };

  // white point divisor (white scaled by 1e7) and rounding offset
  localparam logic [23:0] WDIV [3] = '{24'd9504700, 24'd10000000, 24'd10888300};
  localparam logic [23:0] WHALF [3] = '{24'd4752350, 24'd5000000, 24'd5444150};
  localparam logic [20:0] WRECIP [3] = '{
    21'((64'd1 << N_W) / 64'd9504700),
    21'((64'd1 << N_W) / 64'd10000000),
    21'((64'd1 << N_W) / 64'd10888300)
  };

  // f(t) branch limit and linear branch constants
  localparam logic [Q_W-1:0] CBRT_MIN  = 21'd9287;
  localparam logic [13:0]    KAPPA_MUL = 14'd9033;
  localparam logic [27:0]    KAPPA_ADD = 28'((64'd160 << LIN_SH) + 64'd580);
  localparam int             KAPPA_SH  = 39;
  localparam logic [29:0]    KAPPA_RECIP = 30'(((64'd1 << KAPPA_SH) + 64'd1159) / 64'd1160);

  function automatic lin_t lin_value(int unsigned c);
    longint unsigned t, u, lo, hi, mid, a;
    lo = 0;
    hi = 64'd1 << LIN_SH;
    if (c <= 10) begin
      return lin_t'((64'(c) * 64'd100 * (64'd1 << LIN_SH) + 64'd164730) / 64'd329460);
    end
    t = (((64'd1000 * 64'(c) + 64'd14025) << LIN_SH) + 64'd134512) / 64'd269025;
    u = (t * t + (64'd1 << (LIN_SH - 1))) >> LIN_SH;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      a = (mid * mid) >> LIN_SH;
      a = (a * a) >> LIN_SH;
      a = (a * mid) >> LIN_SH;
      if (a <= u) lo = mid;
      else hi = mid - 64'd1;
    end
    return lin_t'((u * lo + (64'd1 << (LIN_SH - 1))) >> LIN_SH);
  endfunction

  function automatic logic [256*LIN_W-1:0] build_lin_tab();
    logic [256*LIN_W-1:0] tab;
    tab = '0;
    for (int c = 0; c < 256; c++) tab[c*LIN_W +: LIN_W] = lin_value(c);
    return tab;
  endfunction

  localparam logic [256*LIN_W-1:0] LIN_TAB = build_lin_tab();

  function automatic lin_t lin_lookup(logic [7:0] c);
    return LIN_TAB[int'(c)*LIN_W +: LIN_W];
  endfunction

endpackage

>>> rtl/core/slc_if.sv
interface slc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface slc_out_if;
  logic               valid;
  logic               ready;
  logic        [14:0] lightness;
  logic signed [15:0] green_red_axis;
  logic signed [15:0] blue_yellow_axis;
  modport source (output valid, lightness, green_red_axis, blue_yellow_axis, input ready);
  modport sink (input valid, lightness, green_red_axis, blue_yellow_axis, output ready);
endinterface

>>> rtl/core/slc_front.sv
module slc_front import slc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       vin,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       vout,
  output ratio_t     ratio [3],
  output logic       cbrt_sel [3],
  output ratio_t     flin [3]
);

  logic [6:0] v_r;
  lin_t   lin_r   [3];
  num_t   n1_r    [3];
  num_t   n2_r    [3];
  ratio_t qe2_r   [3];
  rem_t   r3_r    [3];
  ratio_t qe3_r   [3];
  ratio_t q4_r    [3];
  lnum_t  lnum5_r [3];
  ratio_t q5_r    [3];
  logic   sel5_r  [3];
  ratio_t q6_r    [3];
  logic   sel6_r  [3];
  ratio_t flin6_r [3];
  logic [7:0] code [3];

  assign code[0] = red;
  assign code[1] = green;
  assign code[2] = blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], vin};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ch
    logic [45:0] prod_sum;
    logic [52:0] qe_prod;
    logic [44:0] qd;
    rem_t        r_a;
    ratio_t      q_a;
    rem_t        r_b;
    ratio_t      q_b;
    logic [58:0] kprod;

    assign prod_sum = 46'(MAT[i][0] * lin_r[0]) + 46'(MAT[i][1] * lin_r[1])
                    + 46'(MAT[i][2] * lin_r[2]) + 46'(WHALF[i]);
    assign qe_prod  = 53'(n1_r[i][N_W-1:12] * WRECIP[i]);
    assign qd       = 45'(qe2_r[i] * WDIV[i]);

    // estimate is low by at most three
    always_comb begin
      r_a = r3_r[i];
      q_a = qe3_r[i];
      if (r3_r[i] >= rem_t'({WDIV[i], 1'b0})) begin
        r_a = r3_r[i] - rem_t'({WDIV[i], 1'b0});
        q_a = qe3_r[i] + ratio_t'(2);
      end
      r_b = r_a;
      q_b = q_a;
      if (r_a >= rem_t'(WDIV[i])) begin
        r_b = r_a - rem_t'(WDIV[i]);
        q_b = q_a + ratio_t'(1);
      end
    end

    assign kprod = 59'(lnum5_r[i] * KAPPA_RECIP);

    always_ff @(posedge clk) begin
      if (en) begin
        lin_r[i]   <= lin_lookup(code[i]);
        n1_r[i]    <= num_t'(prod_sum);
        n2_r[i]    <= n1_r[i];
        qe2_r[i]   <= qe_prod[52:32];
        r3_r[i]    <= rem_t'(45'(n2_r[i]) - qd);
        qe3_r[i]   <= qe2_r[i];
        q4_r[i]    <= q_b;
        lnum5_r[i] <= lnum_t'(q4_r[i][13:0] * KAPPA_MUL) + lnum_t'(KAPPA_ADD);
        q5_r[i]    <= q4_r[i];
        sel5_r[i]  <= (q4_r[i] >= CBRT_MIN);
        q6_r[i]    <= q5_r[i];
        sel6_r[i]  <= sel5_r[i];
        flin6_r[i] <= ratio_t'(kprod >> KAPPA_SH);
      end
    end

    assign ratio[i]    = q6_r[i];
    assign cbrt_sel[i] = sel6_r[i];
    assign flin[i]     = flin6_r[i];
  end

  assign vout = v_r[6];

endmodule

>>> rtl/core/slc_cbrt.sv
module slc_cbrt import slc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   vin,
  input  ratio_t ratio [3],
  input  logic   cbrt_sel [3],
  input  ratio_t flin [3],
  output logic   vout,
  output ratio_t f [3]
);

  logic [CB_STEPS-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[CB_STEPS-2:0], vin};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ch
    ratio_t      q_r   [CB_STEPS];
    logic        sel_r [CB_STEPS];
    ratio_t      fl_r  [CB_STEPS];
    ratio_t      y_r   [CB_STEPS];
    logic [41:0] y2_r  [CB_STEPS];
    logic [43:0] rm_r  [CB_STEPS];

    // one result bit per stage, restoring digit recurrence on three radicand bits
    for (genvar k = 0; k < CB_STEPS; k++) begin : g_st
      ratio_t      q_p, fl_p, y_p;
      logic        sel_p;
      logic [41:0] y2_p;
      logic [43:0] rm_p;
      logic [62:0] tgt;
      logic [46:0] rs, t;
      ratio_t      ys;
      logic [41:0] y2s;

      if (k == 0) begin : g_first
        assign q_p   = ratio[i];
        assign sel_p = cbrt_sel[i];
        assign fl_p  = flin[i];
        assign y_p   = '0;
        assign y2_p  = '0;
        assign rm_p  = '0;
      end else begin : g_next
        assign q_p   = q_r[k-1];
        assign sel_p = sel_r[k-1];
        assign fl_p  = fl_r[k-1];
        assign y_p   = y_r[k-1];
        assign y2_p  = y2_r[k-1];
        assign rm_p  = rm_r[k-1];
      end

      assign tgt = {2'b00, q_p, 40'd0};
      assign rs  = {rm_p, tgt[62-3*k -: 3]};
      assign ys  = {y_p[Q_W-2:0], 1'b0};
      assign y2s = {y2_p[39:0], 2'b00};
      assign t   = 47'(y2s) + 47'({y2s, 1'b0}) + 47'(ys) + 47'({ys, 1'b0}) + 47'd1;

      always_ff @(posedge clk) begin
        if (en) begin
          q_r[k]   <= q_p;
          sel_r[k] <= sel_p;
          fl_r[k]  <= fl_p;
          if (rs >= t) begin
            rm_r[k] <= 44'(rs - t);
            y_r[k]  <= ys + ratio_t'(1);
            y2_r[k] <= y2s + 42'({ys, 1'b0}) + 42'd1;
          end else begin
            rm_r[k] <= 44'(rs);
            y_r[k]  <= ys;
            y2_r[k] <= y2s;
          end
        end
      end
    end

    assign f[i] = sel_r[CB_STEPS-1] ? y_r[CB_STEPS-1] : fl_r[CB_STEPS-1];
  end

  assign vout = v_r[CB_STEPS-1];

endmodule

>>> rtl/core/slc_lab.sv
module slc_lab import slc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vin,
  input  ratio_t             f [3],
  output logic               vout,
  output logic        [14:0] lightness,
  output logic signed [15:0] green_red_axis,
  output logic signed [15:0] blue_yellow_axis
);

  localparam int SH = LIN_SH - FRAC_BITS;
  localparam logic signed [31:0] HALF = 32'sd1 <<< (SH - 1);

  logic               vout_r;
  logic        [14:0] l_r;
  logic signed [15:0] a_r, b_r;
  logic signed [31:0] lv, av, bv, lm, am, bm;

  // round half away from zero
  function automatic logic signed [31:0] rnd(logic signed [31:0] v);
    if (v >= 0) return (v + HALF) >>> SH;
    return -((-v + HALF) >>> SH);
  endfunction

  always_comb begin
    lv = 32'sd116 * $signed({11'd0, f[1]}) - (32'sd16 <<< LIN_SH);
    av = 32'sd500 * ($signed({11'd0, f[0]}) - $signed({11'd0, f[1]}));
    bv = 32'sd200 * ($signed({11'd0, f[1]}) - $signed({11'd0, f[2]}));
    lm = rnd(lv);
    am = rnd(av);
    bm = rnd(bv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (en) begin
      vout_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (lm < 0) l_r <= '0;
      else if (lm > 32'sd32767) l_r <= 15'h7fff;
      else l_r <= lm[14:0];
      if (am < -32'sd32768) a_r <= 16'sh8000;
      else if (am > 32'sd32767) a_r <= 16'sh7fff;
      else a_r <= am[15:0];
      if (bm < -32'sd32768) b_r <= 16'sh8000;
      else if (bm > 32'sd32767) b_r <= 16'sh7fff;
      else b_r <= bm[15:0];
    end
  end

  assign vout             = vout_r;
  assign lightness        = l_r;
  assign green_red_axis   = a_r;
  assign blue_yellow_axis = b_r;

endmodule

>>> rtl/core/srgb_to_cielab.sv
// srgb to cielab (d65, 2 degree observer), one pixel per beat
// the result passes the front, cube root and lab register stages in that order
// throughput: one pixel per cycle unless stalled; every stage is one register level of a single pipeline
// a stall on the output freezes the whole pipeline, no beat is lost or repeated
// reset (rst_n low, synchronous) clears all valid bits; data registers are not reset
module srgb_to_cielab import slc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  slc_in_if.sink    in_if,
  slc_out_if.source out_if
);

  // pipeline advances whenever the output register is free or being drained
  logic   en;
  logic   v_front, v_cbrt;
  ratio_t ratio [3];
  logic   cbrt_sel [3];
  ratio_t flin [3];
  ratio_t f [3];

  assign en          = out_if.ready || !out_if.valid;
  assign in_if.ready = en;

  // linearize table, matrix, white divide (reciprocal plus correction), kappa branch
  slc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vin      (in_if.valid),
    .red      (in_if.red),
    .green    (in_if.green),
    .blue     (in_if.blue),
    .vout     (v_front),
    .ratio    (ratio),
    .cbrt_sel (cbrt_sel),
    .flin     (flin)
  );

  // 21 stage cube root, one result bit per stage, picks cbrt or kappa branch
  slc_cbrt u_cbrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vin      (v_front),
    .ratio    (ratio),
    .cbrt_sel (cbrt_sel),
    .flin     (flin),
    .vout     (v_cbrt),
    .f        (f)
  );

  // L, a, b scaling, rounding and saturation into the output register
  slc_lab #(.FRAC_BITS(FRAC_BITS)) u_lab (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .vin              (v_cbrt),
    .f                (f),
    .vout             (out_if.valid),
    .lightness        (out_if.lightness),
    .green_red_axis   (out_if.green_red_axis),
    .blue_yellow_axis (out_if.blue_yellow_axis)
  );

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_if.valid)
    else $error("result beat right after reset");
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_if.valid |-> in_if.ready)
    else $error("input blocked with empty output");
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |-> !in_if.ready)
    else $error("input taken during output stall");
`endif

endmodule

>>> tb/srgb_to_cielab_tb.sv
module srgb_to_cielab_tb;
  import slc_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  // pipeline depth plus margin, used for the drain at the end
  localparam int DRAIN_CYCLES = 60;
  // cycles with no beat on either side before the run is declared hung
  localparam int STUCK_LIMIT = 5000;
  localparam int RANDOM_PIXELS = 1750;

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] green_red_axis;
    logic signed [15:0] blue_yellow_axis;
  } lab_pix_t;

  // expected lab values, computed in q20 integer arithmetic
  class lab_scoreboard;
    lab_pix_t pending[$];
    longint unsigned gamma_lut[256];
    int errors;

    function new();
      errors = 0;
      for (int c = 0; c < 256; c++) gamma_lut[c] = decode_gamma(c);
    endfunction

    // q20 fifth power with truncation after each product
    function longint unsigned pow5_q20(longint unsigned r);
      longint unsigned p;
      p = (r * r) >> 20;
      p = (p * p) >> 20;
      return (p * r) >> 20;
    endfunction

    // srgb transfer curve, u is the squared base and lo its fifth root
    function longint unsigned decode_gamma(int c);
      longint unsigned t, u, lo, hi, mid, cc;
      cc = c;
      if (c <= 10) return (cc * 100 * (64'd1 << 20) + 164730) / 329460;
      t = (((1000 * cc + 14025) << 20) + 134512) / 269025;
      u = (t * t + (64'd1 << 19)) >> 20;
      lo = 0;
      hi = 64'd1 << 20;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (pow5_q20(mid) <= u) lo = mid;
        else hi = mid - 1;
      end
      return (u * lo + (64'd1 << 19)) >> 20;
    endfunction

    // cube root above epsilon, kappa line below
    function longint lab_curve(longint unsigned q);
      longint unsigned tgt, lo, hi, mid;
      if (q * 1000000 > (64'd8856 << 20)) begin
        tgt = q << 40;
        lo = 0;
        hi = (64'd1 << 21) - 1;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (mid * mid * mid <= tgt) lo = mid;
          else hi = mid - 1;
        end
        return longint'(lo);
      end
      return longint'((9033 * q + (64'd160 << 20) + 580) / 1160);
    endfunction

    // q20 to output format, half away from zero
    function longint to_out(longint v);
      longint unsigned h, m;
      h = 64'd1 << (20 - FRAC - 1);
      if (v >= 0) begin
        m = (longint'(v) + h) >> (20 - FRAC);
        return longint'(m);
      end
      m = (longint'(-v) + h) >> (20 - FRAC);
      return -longint'(m);
    endfunction

    function lab_pix_t pixel_to_lab(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      longint unsigned lin[3], s, d;
      longint unsigned mat[3][3];
      longint unsigned wht[3];
      longint fv[3], lv, av, bv;
      lab_pix_t res;
      mat = '{'{4124564, 3575761, 1804375},
              '{2126729, 7151522, 721750},
              '{193339, 1191920, 9503041}};
      wht = '{95047, 100000, 108883};
      lin[0] = gamma_lut[r];
      lin[1] = gamma_lut[g];
      lin[2] = gamma_lut[b];
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int j = 0; j < 3; j++) s += mat[i][j] * lin[j];
        d = 64'd10000000 * wht[i];
        fv[i] = lab_curve((s * 100000 + d / 2) / d);
      end
      lv = to_out(116 * fv[1] - (longint'(16) << 20));
      av = to_out(500 * (fv[0] - fv[1]));
      bv = to_out(200 * (fv[1] - fv[2]));
      if (lv < 0) lv = 0;
      if (lv > 32767) lv = 32767;
      if (av < -32768) av = -32768;
      if (av > 32767) av = 32767;
      if (bv < -32768) bv = -32768;
      if (bv > 32767) bv = 32767;
      res.lightness = lv[14:0];
      res.green_red_axis = av[15:0];
      res.blue_yellow_axis = bv[15:0];
      return res;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pending = {pending, pixel_to_lab(r, g, b)};
    endfunction

    function void check_lab(lab_pix_t got);
      lab_pix_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result L=%0d a=%0d b=%0d", $time, got.lightness,
                 got.green_red_axis, got.blue_yellow_axis);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.lightness !== want.lightness) begin
        $display("%0t: lightness expected %0d actual %0d", $time, want.lightness,
                 got.lightness);
        errors++;
      end
      if (got.green_red_axis !== want.green_red_axis) begin
        $display("%0t: green_red_axis expected %0d actual %0d", $time,
                 want.green_red_axis, got.green_red_axis);
        errors++;
      end
      if (got.blue_yellow_axis !== want.blue_yellow_axis) begin
        $display("%0t: blue_yellow_axis expected %0d actual %0d", $time,
                 want.blue_yellow_axis, got.blue_yellow_axis);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  slc_in_if  pix_in ();
  slc_out_if lab_out ();

  srgb_to_cielab u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (pix_in.sink),
    .out_if(lab_out.source)
  );

  lab_scoreboard sb;
  int send_idle_pct;   // chance in percent that the sender skips a cycle
  int recv_idle_pct;   // chance in percent that the receiver stalls a cycle
  int hold_cycles;     // pending long stall of the receiver
  int quiet_cycles;    // cycles since the last beat on either side

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off while the sender keeps pushing
  initial begin
    lab_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        lab_out.ready <= 1'b0;
      end else begin
        lab_out.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor both channels at the rising edge, values were driven at the falling one
  always @(posedge clk) begin
    bit beat;
    beat = 1'b0;
    if (rst_n && pix_in.valid && pix_in.ready) begin
      sb.note_pixel(pix_in.red, pix_in.green, pix_in.blue);
      beat = 1'b1;
    end
    if (rst_n && lab_out.valid && lab_out.ready) begin
      sb.check_lab({lab_out.lightness, lab_out.green_red_axis, lab_out.blue_yellow_axis});
      beat = 1'b1;
    end
    quiet_cycles <= beat ? 0 : quiet_cycles + 1;
  end

  // watchdog on a hung pipeline
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (quiet_cycles >= STUCK_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STUCK_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // offer one pixel and hold it until the block takes it
  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.red   <= r;
    pix_in.green <= g;
    pix_in.blue  <= b;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  // mostly uniform codes, with some near black and near white where the curves bend
  function automatic logic [7:0] pick_code();
    case ($urandom_range(9))
      0:       return 8'($urandom_range(16));
      1:       return 8'($urandom_range(255, 240));
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic push_random(int n);
    logic [7:0] v;
    for (int k = 0; k < n; k++) begin
      // one in eight is a neutral grey, so a and b sit near zero
      if ($urandom_range(7) == 0) begin
        v = pick_code();
        push_pixel(v, v, v);
      end else begin
        push_pixel(pick_code(), pick_code(), pick_code());
      end
    end
  endtask

  initial begin
    sb = new();
    hold_cycles = 0;
    send_idle_pct = 6;
    recv_idle_pct = 73;
    rst_n = 1'b0;
    pix_in.valid = 1'b0;
    pix_in.red = '0;
    pix_in.green = '0;
    pix_in.blue = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // black, white, primaries and secondaries
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd255);
    // edge of the linear segment of the transfer curve
    push_pixel(8'd10, 8'd10, 8'd10);
    push_pixel(8'd11, 8'd11, 8'd11);
    push_pixel(8'd10, 8'd11, 8'd10);
    // near black: f(t) takes the kappa line
    push_pixel(8'd1, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd1, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd1);
    push_pixel(8'd2, 8'd2, 8'd2);
    push_pixel(8'd8, 8'd9, 8'd7);
    // around epsilon of the lab curve
    push_pixel(8'd24, 8'd24, 8'd24);
    push_pixel(8'd25, 8'd25, 8'd25);
    // alternating bit patterns and mixed extremes
    push_pixel(8'h55, 8'hAA, 8'h55);
    push_pixel(8'hAA, 8'h55, 8'hAA);
    push_pixel(8'd128, 8'd128, 8'd128);
    push_pixel(8'd255, 8'd0, 8'd128);
    push_pixel(8'd0, 8'd128, 8'd255);

    push_random(RANDOM_PIXELS / 3);

    // roles swapped: sender sparse, receiver nearly always ready
    send_idle_pct = 73;
    recv_idle_pct = 6;
    push_random(RANDOM_PIXELS / 3);

    // full rate, opened by a long receiver hold-off so the pipeline backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 150;
    push_random(RANDOM_PIXELS - 2 * (RANDOM_PIXELS / 3));

    @(negedge clk);
    pix_in.valid <= 1'b0;

    // drain, the watchdog covers a pipeline that never empties
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/slc_pkg.sv
rtl/core/slc_if.sv
rtl/core/slc_front.sv
rtl/core/slc_cbrt.sv
rtl/core/slc_lab.sv
rtl/core/srgb_to_cielab.sv
tb/srgb_to_cielab_tb.sv
